FILE: rtl/core/mse_pkg.sv
// package: shared types, constants and letter lookup for the morse unit stream encoder
`timescale 1ns / 1ps

package mse_pkg;

    // character codes
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // run lengths in time units
    localparam logic [2:0] WORD_GAP_UNITS   = 3'd7;
    localparam logic [2:0] LETTER_GAP_UNITS = 3'd3;
    localparam logic [2:0] DASH_UNITS       = 3'd3;
    localparam logic [2:0] DOT_UNITS        = 3'd1;
    localparam logic [2:0] ELEM_GAP_UNITS   = 3'd1;

    // letter table: {element count, dash mask}, bit k of the mask set means element k is a dash
    localparam logic [6:0] LETTER_TABLE [26] = '{
        {3'd2, 4'b0010},  // A .-
        {3'd4, 4'b0001},  // B -...
        {3'd4, 4'b0101},  // C -.-.
        {3'd3, 4'b0001},  // D -..
        {3'd1, 4'b0000},  // E .
        {3'd4, 4'b0100},  // F ..-.
        {3'd3, 4'b0011},  // G --.
        {3'd4, 4'b0000},  // H ....
        {3'd2, 4'b0000},  // I ..
        {3'd4, 4'b1110},  // J .---
        {3'd3, 4'b0101},  // K -.-
        {3'd4, 4'b0010},  // L .-..
        {3'd2, 4'b0011},  // M --
        {3'd2, 4'b0001},  // N -.
        {3'd3, 4'b0111},  // O ---
        {3'd4, 4'b0110},  // P .--.
        {3'd4, 4'b1011},  // Q --.-
        {3'd3, 4'b0010},  // R .-.
        {3'd3, 4'b0000},  // S ...
        {3'd1, 4'b0001},  // T -
        {3'd3, 4'b0100},  // U ..-
        {3'd4, 4'b1000},  // V ...-
        {3'd3, 4'b0110},  // W .--
        {3'd4, 4'b1001},  // X -..-
        {3'd4, 4'b1101},  // Y -.--
        {3'd4, 4'b0011}   // Z --..
    };

    // decoded character
    typedef struct packed {
        logic       is_space;
        logic [2:0] elem_count;
        logic [3:0] dash_mask;
    } char_info_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       emit;
        logic       level;
        logic       last;
        logic       cnt_load;
        logic [2:0] cnt_val;
        logic       shift;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_space;
        logic len_zero;
        logic len_one;
        logic dash;
        logic cnt_one;
        logic out_free;
    } dp_stat_t;

    // fold case and look up the element pattern
    function automatic char_info_t morse_lookup(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] idx;
        char_info_t r;
        u = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            u = c - CASE_OFFSET;
        end
        idx = u - CHAR_UPPER_A;
        r = '0;
        if (u == CHAR_SPACE)
        begin
            r.is_space = 1'b1;
        end
        else if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z)
        begin
            {r.elem_count, r.dash_mask} = LETTER_TABLE[idx[4:0]];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/mse_char_if.sv
// interface: character input channel
`timescale 1ns / 1ps

interface mse_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

FILE: rtl/core/mse_unit_if.sv
// interface: keying unit output channel
`timescale 1ns / 1ps

interface mse_unit_if;
    logic valid;
    logic ready;
    logic key_level;
    logic last_unit;

    modport source (output valid, output key_level, output last_unit, input ready);
    modport sink (input valid, input key_level, input last_unit, output ready);
endinterface

FILE: rtl/core/mse_ctrl.sv
// controller: sequences dots, dashes and gaps of one character
`timescale 1ns / 1ps

module mse_ctrl
    import mse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ON,
        ST_IGAP,
        ST_LGAP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.cnt_load = 1'b1;
                if (stat.is_space)
                begin
                    cmd.cnt_val = WORD_GAP_UNITS;
                    state_next  = ST_LGAP;
                end
                else if (stat.len_zero)
                begin
                    cmd.cnt_val = LETTER_GAP_UNITS;
                    state_next  = ST_LGAP;
                end
                else
                begin
                    cmd.cnt_val = stat.dash ? DASH_UNITS : DOT_UNITS;
                    state_next  = ST_ON;
                end
            end
            ST_ON:
            begin
                if (stat.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.level = 1'b1;
                    if (stat.cnt_one)
                    begin
                        cmd.shift    = 1'b1;
                        cmd.cnt_load = 1'b1;
                        if (stat.len_one)
                        begin
                            cmd.cnt_val = LETTER_GAP_UNITS;
                            state_next  = ST_LGAP;
                        end
                        else
                        begin
                            cmd.cnt_val = ELEM_GAP_UNITS;
                            state_next  = ST_IGAP;
                        end
                    end
                end
            end
            ST_IGAP:
            begin
                // single off unit, then the next element already at the mask head
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.cnt_load = 1'b1;
                    cmd.cnt_val  = stat.dash ? DASH_UNITS : DOT_UNITS;
                    state_next   = ST_ON;
                end
            end
            ST_LGAP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = stat.cnt_one;
                    if (stat.cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/mse_dpath.sv
// datapath: character decode, element shifter, unit counter and output register
`timescale 1ns / 1ps

module mse_dpath
    import mse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_code,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    input  logic       out_ready,
    output logic       out_valid,
    output logic       key_level,
    output logic       last_unit
);

    logic       space_reg;
    logic [2:0] len_reg;
    logic [3:0] mask_reg;
    logic [2:0] cnt_reg;
    logic       valid_reg;
    logic       key_reg;
    logic       last_reg;
    char_info_t info;

    assign info = morse_lookup(char_code);

    // character pattern, consumed one element at a time
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            space_reg <= info.is_space;
            len_reg   <= info.elem_count;
            mask_reg  <= info.dash_mask;
        end
        else if (cmd.shift)
        begin
            len_reg  <= len_reg - 3'd1;
            mask_reg <= {1'b0, mask_reg[3:1]};
        end
    end

    // units left in the current run
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_load)
        begin
            cnt_reg <= cmd.cnt_val;
        end
        else if (cmd.emit)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            key_reg  <= cmd.level;
            last_reg <= cmd.last;
        end
    end

    // status back to the controller
    always_comb
    begin
        stat.is_space = space_reg;
        stat.len_zero = (len_reg == 3'd0);
        stat.len_one  = (len_reg == 3'd1);
        stat.dash     = mask_reg[0];
        stat.cnt_one  = (cnt_reg == 3'd1);
        stat.out_free = !valid_reg || out_ready;
    end

    assign out_valid = valid_reg;
    assign key_level = key_reg;
    assign last_unit = last_reg;

endmodule

FILE: rtl/core/morse_unit_stream_encoder_unit.sv
// top level: morse unit stream encoder
`timescale 1ns / 1ps
//
// Takes one 8-bit character per transfer on char_in and plays out its Morse
// keying pattern on unit_out, one key level per transfer, with last_unit set on
// the final unit of the character. Lower-case letters are folded to upper case,
// a space gives seven off units, any other non-letter three off units.
// Flow: the input transfer, then a decode step in the START state, then one
// unit per cycle while the receiver accepts them, each held in the output
// register until it is taken. The character sequencer in the controller
// handles one character at a time and char_in.ready is high only while it is
// idle; the last unit may still sit in the output register when the next
// character is taken.
// When the receiver stalls, the output register holds its unit and the
// sequencer waits on it.
// Reset empties the output register and returns the sequencer to idle; the
// pattern, unit counter, key and last registers are not reset.
//

module morse_unit_stream_encoder_unit
    import mse_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    mse_char_if.sink   char_in,
    mse_unit_if.source unit_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    mse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    mse_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_in.char_code),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (unit_out.ready),
        .out_valid (unit_out.valid),
        .key_level (unit_out.key_level),
        .last_unit (unit_out.last_unit)
    );

endmodule

FILE: rtl/core/mse_checker.sv
// checker: port-level assertions for the morse unit stream encoder, with bind
`timescale 1ns / 1ps

module mse_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic key_level,
    input logic last_unit
);

    // one character at a time: no new transfer right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a character is in progress");

    // a waiting unit at input-ready time can only be the end of the previous character
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && out_valid) |-> last_unit)
    else $error("input ready with a character still mid-stream");

    // every character ends in an off unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_unit) |-> !key_level)
    else $error("last unit of a character is keyed on");

    // stalled unit holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(key_level) && $stable(last_unit)))
    else $error("output changed while stalled");

endmodule

bind morse_unit_stream_encoder_unit mse_checker u_mse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_in.valid),
    .in_ready  (char_in.ready),
    .out_valid (unit_out.valid),
    .out_ready (unit_out.ready),
    .key_level (unit_out.key_level),
    .last_unit (unit_out.last_unit)
);
